### rtl/core/pip_pkg.sv
package pip_pkg;

  localparam int MAX_VERTICES_DEF = 256;
  localparam int COORD_BITS_DEF   = 16;
  localparam int RAY_END_X        = 1000000;
  localparam int MIN_POLY         = 3;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_TEST   = 2'd2;

  localparam logic [1:0] TURN_COL = 2'd0;
  localparam logic [1:0] TURN_CW  = 2'd1;
  localparam logic [1:0] TURN_CCW = 2'd2;

  typedef struct packed {
    logic v;
    logic last;
    logic hit;
    logic coll;
    logic onseg;
  } edge_res_t;

endpackage

### rtl/core/pip_ram.sv
module pip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/pip_edge.sv
module pip_edge import pip_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         flush,
  input  logic                         in_v,
  input  logic                         in_last,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  input  logic signed [COORD_BITS-1:0] qx,
  input  logic signed [COORD_BITS-1:0] qy,
  output edge_res_t                    res
);

  localparam int DW = COORD_BITS + 1;
  localparam int EW = $clog2(RAY_END_X + 2 ** (COORD_BITS - 1) + 1) + 1;
  localparam int PW = DW + EW;
  localparam logic signed [EW-1:0] RAY_X = EW'(RAY_END_X);

  // stage 1: differences and compares
  logic signed [DW-1:0] dx_c, dy_c, qy_c, pxa_c;
  logic signed [EW-1:0] exa_c;
  logic                 pbox_c, ebox_c, t3box_c, t4box_c;
  logic [1:0]           t3_c, t4_c;
  logic signed [EW-1:0] axe, bxe;

  logic                 s1_v, s1_last;
  logic signed [DW-1:0] dx, dy, qyd, pxa;
  logic signed [EW-1:0] exa;
  logic                 pbox1, ebox1, t3box1, t4box1;
  logic [1:0]           t31, t41;

  // stage 2: products
  logic                 s2_v, s2_last;
  logic signed [PW-1:0] m0, m1, m2;
  logic                 pbox2, ebox2, t3box2, t4box2;
  logic [1:0]           t32, t42;

  logic signed [PW:0]   v1, v2;
  logic [1:0]           t1, t2;
  logic                 hit;

  always_comb begin
    axe   = EW'(ax);
    bxe   = EW'(bx);
    dx_c  = DW'(bx) - DW'(ax);
    dy_c  = DW'(by) - DW'(ay);
    qy_c  = DW'(qy) - DW'(ay);
    pxa_c = DW'(qx) - DW'(ax);
    exa_c = RAY_X - axe;
    pbox_c = ((qx <= ax) || (qx <= bx)) && ((qx >= ax) || (qx >= bx)) &&
             ((qy <= ay) || (qy <= by)) && ((qy >= ay) || (qy >= by));
    ebox_c = ((RAY_X <= axe) || (RAY_X <= bxe)) && ((RAY_X >= axe) || (RAY_X >= bxe)) &&
             ((qy <= ay) || (qy <= by)) && ((qy >= ay) || (qy >= by));
    t3_c = (ay < qy) ? TURN_CW : ((ay > qy) ? TURN_CCW : TURN_COL);
    t4_c = (by < qy) ? TURN_CW : ((by > qy) ? TURN_CCW : TURN_COL);
    t3box_c = (ax >= qx) && (axe <= RAY_X) && (ay == qy);
    t4box_c = (bx >= qx) && (bxe <= RAY_X) && (by == qy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= in_v && !flush;
      s2_v <= s1_v && !flush;
    end
    s1_last <= in_last;
    dx      <= dx_c;
    dy      <= dy_c;
    qyd     <= qy_c;
    pxa     <= pxa_c;
    exa     <= exa_c;
    pbox1   <= pbox_c;
    ebox1   <= ebox_c;
    t31     <= t3_c;
    t41     <= t4_c;
    t3box1  <= t3box_c;
    t4box1  <= t4box_c;

    s2_last <= s1_last;
    m0      <= PW'(dx) * PW'(qyd);
    m1      <= PW'(dy) * PW'(pxa);
    m2      <= PW'(dy) * PW'(exa);
    pbox2   <= pbox1;
    ebox2   <= ebox1;
    t32     <= t31;
    t42     <= t41;
    t3box2  <= t3box1;
    t4box2  <= t4box1;
  end

  // stage 3: orientation signs and crossing decision
  always_comb begin
    v1  = (PW + 1)'(m1) - (PW + 1)'(m0);
    v2  = (PW + 1)'(m2) - (PW + 1)'(m0);
    t1  = (v1 == 0) ? TURN_COL : ((v1 > 0) ? TURN_CW : TURN_CCW);
    t2  = (v2 == 0) ? TURN_COL : ((v2 > 0) ? TURN_CW : TURN_CCW);
    hit = ((t1 != t2) && (t32 != t42)) ||
          ((t1 == TURN_COL) && pbox2) ||
          ((t2 == TURN_COL) && ebox2) ||
          ((t32 == TURN_COL) && t3box2) ||
          ((t42 == TURN_COL) && t4box2);
    res.v     = s2_v;
    res.last  = s2_last;
    res.hit   = hit;
    res.coll  = hit && (t1 == TURN_COL);
    res.onseg = pbox2;
  end

endmodule

### rtl/core/point_in_polygon_test.sv
// test: the edges are walked one per cycle from acceptance to result, through the vertex ram
// read and a three stage edge pipeline; fewer than three vertices answer without a walk.
// clear and append complete on acceptance.
// one word in work at a time; a new word is taken while a result waits.
// reset (synchronous, active high) empties the polygon; the vertex ram is not cleared.
module point_in_polygon_test import pip_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            op,
  input  logic [COORD_BITS-1:0] px,
  input  logic [COORD_BITS-1:0] py,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  inside_res,
  output logic                  decided_by_edge
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]                 state;
  logic [CW-1:0]              vcount;
  logic [CW-1:0]              rd_cnt;
  logic                       rd_on;
  logic                       q0_v, q0_first, q0_last;
  logic signed [COORD_BITS-1:0] ax, ay, qx, qy, bx, by;
  logic                       hits;
  logic                       res_in, res_edge;
  logic                       accept, we, flush;
  logic [AW-1:0]              raddr;
  logic [2*COORD_BITS-1:0]    rdata;
  edge_res_t                  e_out;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign we       = accept && (op == OP_APPEND) && (vcount < CW'(MAX_VERTICES));
  assign raddr    = (rd_cnt == vcount) ? '0 : rd_cnt[AW-1:0];
  assign bx       = rdata[2*COORD_BITS-1:COORD_BITS];
  assign by       = rdata[COORD_BITS-1:0];
  assign flush    = (state == ST_WALK) && e_out.v && (e_out.coll || e_out.last);

  pip_ram #(
    .WIDTH (2 * COORD_BITS),
    .DEPTH (MAX_VERTICES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (vcount[AW-1:0]),
    .wdata ({px, py}),
    .raddr (raddr),
    .rdata (rdata)
  );

  pip_edge #(
    .COORD_BITS (COORD_BITS)
  ) u_edge (
    .clk     (clk),
    .rst     (rst),
    .flush   (flush),
    .in_v    (q0_v && !q0_first),
    .in_last (q0_last),
    .ax      (ax),
    .ay      (ay),
    .bx      (bx),
    .by      (by),
    .qx      (qx),
    .qy      (qy),
    .res     (e_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      vcount    <= '0;
      rd_on     <= 1'b0;
      q0_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      q0_v <= rd_on && !flush;
      if ((state == ST_FIN) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (op)
              OP_CLEAR: begin
                vcount <= '0;
              end
              OP_APPEND: begin
                if (we) begin
                  vcount <= vcount + 1'b1;
                end
              end
              OP_TEST: begin
                hits <= 1'b0;
                if (vcount < CW'(MIN_POLY)) begin
                  res_in   <= 1'b0;
                  res_edge <= 1'b0;
                  state    <= ST_FIN;
                end else begin
                  rd_cnt <= '0;
                  rd_on  <= 1'b1;
                  state  <= ST_WALK;
                end
              end
              default: ;
            endcase
          end
        end
        ST_WALK: begin
          if (rd_on) begin
            if ((rd_cnt == vcount) || flush) begin
              rd_on <= 1'b0;
            end else begin
              rd_cnt <= rd_cnt + 1'b1;
            end
          end
          if (e_out.v) begin
            if (e_out.coll) begin
              res_in   <= e_out.onseg;
              res_edge <= 1'b1;
              state    <= ST_FIN;
            end else begin
              hits <= hits ^ e_out.hit;
              if (e_out.last) begin
                res_in   <= hits ^ e_out.hit;
                res_edge <= 1'b0;
                state    <= ST_FIN;
              end
            end
          end
        end
        ST_FIN: begin
          if (!out_valid || out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    q0_first <= (rd_cnt == '0);
    q0_last  <= (rd_cnt == vcount);
    if (q0_v) begin
      ax <= bx;
      ay <= by;
    end
    if (accept) begin
      qx <= px;
      qy <= py;
    end
    if ((state == ST_FIN) && (!out_valid || out_ready)) begin
      inside_res      <= res_in;
      decided_by_edge <= res_edge;
    end
  end

endmodule

### tb/point_in_polygon_test_checker.sv
`timescale 1ns / 100ps
module point_in_polygon_test_checker import pip_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [1:0]            op,
  input  logic [COORD_BITS-1:0] px,
  input  logic [COORD_BITS-1:0] py,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  inside_res,
  input  logic                  decided_by_edge,
  output int                    errors,
  output int                    pending,
  output int                    answers_checked,
  output int                    edge_answers,
  output int                    inside_answers
);

  typedef struct packed {
    longint x;
    longint y;
  } pt_t;

  typedef struct packed {
    logic is_in;
    logic by_edge;
  } verdict_t;

  pt_t         poly_pts [MAX_VERTICES];
  int unsigned poly_len;
  verdict_t    answers_due [$];
  verdict_t    want;
  pt_t         probe_pt;

  initial begin
    errors          = 0;
    pending         = 0;
    answers_checked = 0;
    edge_answers    = 0;
    inside_answers  = 0;
    poly_len        = 0;
  end

  task automatic flag_mismatch(input string what);
    $display("mismatch at answer %0d: %s", answers_checked, what);
    errors++;
  endtask

  function automatic logic [1:0] turn_of(input pt_t a, input pt_t b, input pt_t c);
    longint v;
    v = (b.y - a.y) * (c.x - b.x) - (b.x - a.x) * (c.y - b.y);
    if (v == 0) return TURN_COL;
    return (v > 0) ? TURN_CW : TURN_CCW;
  endfunction

  function automatic logic in_box(input pt_t a, input pt_t q, input pt_t b);
    longint hi_x, lo_x, hi_y, lo_y;
    hi_x = (a.x > b.x) ? a.x : b.x;
    lo_x = (a.x < b.x) ? a.x : b.x;
    hi_y = (a.y > b.y) ? a.y : b.y;
    lo_y = (a.y < b.y) ? a.y : b.y;
    return q.x <= hi_x && q.x >= lo_x && q.y <= hi_y && q.y >= lo_y;
  endfunction

  function automatic logic segments_meet(input pt_t a1, input pt_t b1,
                                         input pt_t a2, input pt_t b2);
    logic [1:0] t1, t2, t3, t4;
    t1 = turn_of(a1, b1, a2);
    t2 = turn_of(a1, b1, b2);
    t3 = turn_of(a2, b2, a1);
    t4 = turn_of(a2, b2, b1);
    if (t1 != t2 && t3 != t4) return 1'b1;
    if (t1 == TURN_COL && in_box(a1, a2, b1)) return 1'b1;
    if (t2 == TURN_COL && in_box(a1, b2, b1)) return 1'b1;
    if (t3 == TURN_COL && in_box(a2, a1, b2)) return 1'b1;
    if (t4 == TURN_COL && in_box(a2, b1, b2)) return 1'b1;
    return 1'b0;
  endfunction

  // ray cast from the point to the far right, first collinear edge settles it
  function automatic verdict_t cast_ray(input pt_t p);
    verdict_t    res;
    pt_t         far_pt, a, b;
    int unsigned hits;
    res    = '0;
    hits   = 0;
    far_pt = '{x: longint'(RAY_END_X), y: p.y};
    if (poly_len < MIN_POLY) return res;
    for (int unsigned i = 0; i < poly_len; i++) begin
      a = poly_pts[i];
      b = poly_pts[(i + 1) % poly_len];
      if (segments_meet(a, b, p, far_pt)) begin
        if (turn_of(a, p, b) == TURN_COL) begin
          res.is_in   = in_box(a, p, b);
          res.by_edge = 1'b1;
          return res;
        end
        hits++;
      end
    end
    res.is_in = hits[0];
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          flag_mismatch("answer with no test word waiting");
        end else begin
          want = answers_due.pop_front();
          if (inside_res !== want.is_in)
            flag_mismatch($sformatf("inside_res got %b want %b", inside_res, want.is_in));
          if (decided_by_edge !== want.by_edge)
            flag_mismatch($sformatf("decided_by_edge got %b want %b",
                                    decided_by_edge, want.by_edge));
          if (want.by_edge) edge_answers++;
          if (want.is_in) inside_answers++;
        end
        answers_checked++;
      end
      if (in_valid && in_ready) begin
        probe_pt = '{x: longint'($signed(px)), y: longint'($signed(py))};
        case (op)
          OP_CLEAR: begin
            poly_len = 0;
          end
          OP_APPEND: begin
            if (poly_len < MAX_VERTICES) begin
              poly_pts[poly_len] = probe_pt;
              poly_len++;
            end
          end
          OP_TEST: begin
            answers_due = {answers_due, cast_ray(probe_pt)};
          end
          default: ;
        endcase
      end
      pending <= answers_due.size();
    end
  end

endmodule

### tb/point_in_polygon_test_test.sv
`timescale 1ns / 100ps
module point_in_polygon_test_test import pip_pkg::*;;

  localparam int MAXV       = MAX_VERTICES_DEF;
  localparam int WORD_GOAL  = 1200;
  localparam int LONG_HOLD  = 400;
  localparam int LIMIT      = 1500000;
  localparam logic [1:0] OP_NONE = 2'd3;

  logic        clk             = 1'b0;
  logic        rst             = 1'b1;
  logic        in_valid        = 1'b0;
  logic        in_ready;
  logic [1:0]  op              = OP_CLEAR;
  logic [15:0] px              = '0;
  logic [15:0] py              = '0;
  logic        out_valid;
  logic        out_ready       = 1'b0;
  logic        inside_res;
  logic        decided_by_edge;

  int errors, pending, answers_checked, edge_answers, inside_answers;
  int words_sent      = 0;
  int noise_sent      = 0;
  int hold_requests   = 0;
  int cycle_count     = 0;
  int send_calm_left  = 0;
  bit send_calm       = 1'b0;
  int shadow_x [MAXV];
  int shadow_y [MAXV];
  int shadow_len      = 0;

  always #5 clk = ~clk;

  point_in_polygon_test dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .px(px),
    .py(py),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .inside_res(inside_res),
    .decided_by_edge(decided_by_edge)
  );

  point_in_polygon_test_checker chk (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .px(px),
    .py(py),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .inside_res(inside_res),
    .decided_by_edge(decided_by_edge),
    .errors(errors),
    .pending(pending),
    .answers_checked(answers_checked),
    .edge_answers(edge_answers),
    .inside_answers(inside_answers)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("timed out after %0d cycles with %0d answers outstanding", LIMIT, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [15:0] pick_coord(input int mode);
    int v;
    case (mode)
      0: v = int'($urandom_range(0, 12)) - 6;
      1: v = int'($urandom_range(0, 600)) - 300;
      2: v = int'($urandom_range(0, 65535)) - 32768;
      default: begin
        case ($urandom_range(0, 6))
          0: v = -32768;
          1: v = -32767;
          2: v = -1;
          3: v = 0;
          4: v = 1;
          5: v = 32766;
          default: v = 32767;
        endcase
      end
    endcase
    return 16'(v);
  endfunction

  function automatic int pick_mode();
    int r;
    r = $urandom_range(0, 19);
    if (r < 9) return 0;
    if (r < 14) return 1;
    if (r < 18) return 2;
    return 3;
  endfunction

  task automatic send_word(input logic [1:0] o, input logic [15:0] x, input logic [15:0] y);
    int unsigned w;
    if (send_calm_left == 0) begin
      send_calm_left = $urandom_range(5, 40);
      send_calm      = ($urandom_range(0, 2) == 0);
    end
    send_calm_left--;
    w = send_calm ? 0 : $urandom_range(0, 11);
    if (w > 0) begin
      in_valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    px       <= x;
    py       <= y;
    do @(posedge clk); while (!in_ready);
    case (o)
      OP_CLEAR: shadow_len = 0;
      OP_APPEND: begin
        if (shadow_len < MAXV) begin
          shadow_x[shadow_len] = $signed(x);
          shadow_y[shadow_len] = $signed(y);
          shadow_len++;
        end
      end
      default: ;
    endcase
    if (o == OP_NONE) noise_sent++;
    else words_sent++;
  endtask

  task automatic maybe_noise();
    if ($urandom_range(0, 14) == 0) send_word(OP_NONE, pick_coord(2), pick_coord(2));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // query points aimed at vertices, edges and rays through vertices
  task automatic probe(input int mode);
    int kind, i, j;
    logic [15:0] qx, qy;
    kind = $urandom_range(0, 5);
    i    = 0;
    j    = 0;
    if (shadow_len == 0) kind = 0;
    else begin
      i = $urandom_range(0, shadow_len - 1);
      j = (i + 1) % shadow_len;
    end
    case (kind)
      2: begin
        qx = 16'(shadow_x[i]);
        qy = 16'(shadow_y[i]);
      end
      3: begin
        qx = 16'((shadow_x[i] + shadow_x[j]) / 2);
        qy = 16'((shadow_y[i] + shadow_y[j]) / 2);
      end
      4: begin
        qx = pick_coord(mode);
        qy = 16'(shadow_y[i]);
      end
      5: begin
        qx = pick_coord(3);
        qy = 16'(shadow_y[i]);
      end
      default: begin
        qx = pick_coord(mode);
        qy = pick_coord(mode);
      end
    endcase
    send_word(OP_TEST, qx, qy);
  endtask

  task automatic build_and_probe(input bit hold);
    int mode, r, nv, nq;
    mode = pick_mode();
    if ($urandom_range(0, 9) != 0) send_word(OP_CLEAR, pick_coord(2), pick_coord(2));
    r = $urandom_range(0, 19);
    if (r < 3) nv = $urandom_range(0, 2);
    else if (r < 17) nv = $urandom_range(3, 10);
    else nv = $urandom_range(11, 40);
    for (int v = 0; v < nv; v++) begin
      send_word(OP_APPEND, pick_coord(mode), pick_coord(mode));
      maybe_noise();
    end
    nq = hold ? 8 : $urandom_range(1, 6);
    if (hold) hold_requests++;
    for (int q = 0; q < nq; q++) begin
      probe(mode);
      maybe_noise();
    end
  endtask

  // fill the store past capacity, the extra appends are dropped
  task automatic fill_store();
    send_word(OP_CLEAR, pick_coord(3), pick_coord(3));
    for (int v = 0; v < MAXV + 4; v++)
      send_word(OP_APPEND, pick_coord(v % 3 == 0 ? 2 : 0), pick_coord(v % 3 == 0 ? 2 : 0));
    for (int q = 0; q < 3; q++) probe(0);
  endtask

  initial begin : sender
    int seq_no;
    seq_no = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words: empty and small polygons, extreme triangle, unused op
    send_word(OP_TEST, 16'h0000, 16'h0000);
    send_word(OP_APPEND, 16'h8000, 16'h8000);
    send_word(OP_TEST, 16'h8000, 16'h8000);
    send_word(OP_APPEND, 16'h7fff, 16'h8000);
    send_word(OP_TEST, 16'h0000, 16'h8000);
    send_word(OP_APPEND, 16'h0000, 16'h7fff);
    send_word(OP_TEST, 16'h0000, 16'h0000);
    send_word(OP_TEST, 16'h8000, 16'h8000);
    send_word(OP_TEST, 16'h0000, 16'h8000);
    send_word(OP_TEST, 16'h7fff, 16'h7fff);
    send_word(OP_TEST, 16'h8000, 16'h7fff);
    send_word(OP_TEST, 16'h0000, 16'h7fff);
    send_word(OP_NONE, 16'h7fff, 16'hffff);
    send_word(OP_TEST, 16'h8000, 16'h0000);
    send_word(OP_TEST, 16'hffff, 16'h0001);
    send_word(OP_APPEND, 16'h8000, 16'h7fff);
    send_word(OP_TEST, 16'h8000, 16'h0000);
    send_word(OP_TEST, 16'h7fff, 16'h0000);
    send_word(OP_CLEAR, 16'hffff, 16'hffff);
    send_word(OP_TEST, 16'h0000, 16'h0000);
    send_word(OP_NONE, 16'h0000, 16'h0000);
    wait_drained();

    while (words_sent < WORD_GOAL) begin
      seq_no++;
      if (seq_no == 20 || seq_no == 55) fill_store();
      else build_and_probe(seq_no == 8 || seq_no == 45);
      if (seq_no % 15 == 0) wait_drained();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (MAXV + 20) @(posedge clk);
    $display("sent %0d words plus %0d unused-op words, checked %0d test answers",
             words_sent, noise_sent, answers_checked);
    $display("answers settled on an edge: %0d, inside: %0d, long output stalls: %0d",
             edge_answers, inside_answers, hold_requests);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned w;
    int calm_left;
    bit calm;
    int holds_done;
    calm_left  = 0;
    calm       = 1'b0;
    holds_done = 0;
    while (rst) @(posedge clk);
    forever begin
      if (holds_done < hold_requests) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (calm_left == 0) begin
        calm_left = $urandom_range(5, 30);
        calm      = ($urandom_range(0, 2) == 0);
      end
      calm_left--;
      w = calm ? 0 : $urandom_range(0, 11);
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

endmodule
